// File: sv/sorted_table_binary_lookup_unit_defines.svh
// Assertion macros for the sorted table lookup unit.
// Included by the top level; no other dependencies.
`ifndef SORTED_TABLE_BINARY_LOOKUP_UNIT_DEFINES_SVH
`define SORTED_TABLE_BINARY_LOOKUP_UNIT_DEFINES_SVH

// same-cycle implication
`define STBL_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define STBL_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: sv/stbl_pkg.sv
// Shared constants and types for the sorted table lookup unit.
// No dependencies.
package stbl_pkg;

   localparam int TABLE_ENTRIES = 256;
   localparam int ADDR_W        = $clog2(TABLE_ENTRIES);
   localparam int INDEX_W       = 8;
   localparam int KEY_W         = 32;
   localparam int DATA_W        = 32;
   // search bounds: bottom up to TABLE_ENTRIES, top down to -1
   localparam int BT_W          = ADDR_W + 2;

   localparam logic OP_WRITE  = 1'b0;
   localparam logic OP_LOOKUP = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_PROBE,
      ST_HOLD
   } state_type;

   typedef struct packed {
      logic [DATA_W-1:0] length;
      logic [DATA_W-1:0] offset;
      logic [KEY_W-1:0]  key;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   typedef struct packed {
      logic                   hit;
      logic                   done;
      logic signed [BT_W-1:0] bottom;
      logic signed [BT_W-1:0] top;
      logic [ADDR_W-1:0]      mid;
   } probe_type;

   typedef struct packed {
      logic              found;
      logic [DATA_W-1:0] offset;
      logic [DATA_W-1:0] length;
   } result_type;

endpackage

// File: sv/stbl_ram.sv
// Simple dual-port table memory, one write and one registered read per cycle.
// No dependencies.
module stbl_ram #(
   parameter int DEPTH = 256,
   parameter int WIDTH = 96
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: sv/stbl_probe.sv
// Compare and bound update for one search probe, plus the next midpoint.
// Depends on stbl_pkg.
module stbl_probe (
   input  logic [stbl_pkg::KEY_W-1:0]         key,
   input  logic [stbl_pkg::KEY_W-1:0]         entry_key,
   input  logic signed [stbl_pkg::BT_W-1:0]   bottom,
   input  logic signed [stbl_pkg::BT_W-1:0]   top,
   input  logic [stbl_pkg::ADDR_W-1:0]        mid,
   output stbl_pkg::probe_type                result
);

   logic                             greater;
   logic                             equal;
   logic signed [stbl_pkg::BT_W-1:0] mid_s;
   logic signed [stbl_pkg::BT_W-1:0] bottom_n;
   logic signed [stbl_pkg::BT_W-1:0] top_n;
   logic signed [stbl_pkg::BT_W:0]   sum;

   always_comb begin
      greater = key > entry_key;
      equal   = key == entry_key;
      mid_s   = $signed({2'b00, mid});
      if (greater) begin
         bottom_n = bottom;
         top_n    = mid_s - stbl_pkg::BT_W'(1);
      end else begin
         bottom_n = mid_s + stbl_pkg::BT_W'(1);
         top_n    = top;
      end
      sum = (stbl_pkg::BT_W+1)'(bottom_n) + (stbl_pkg::BT_W+1)'(top_n);

      result.hit    = equal;
      result.done   = equal || (bottom_n == mid_s) || (top_n == mid_s)
                      || (bottom_n > top_n) || top_n[stbl_pkg::BT_W-1];
      result.bottom = bottom_n;
      result.top    = top_n;
      result.mid    = sum[stbl_pkg::ADDR_W:1];
   end

endmodule

// File: sv/stbl_seq.sv
// Lookup sequencer: item intake, probe loop around the shared compare unit,
// result register. Depends on stbl_pkg and stbl_probe.
module stbl_seq (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic                          req_op,
   input  logic [stbl_pkg::KEY_W-1:0]    req_key,
   output logic                          req_ready,
   input  logic [stbl_pkg::INDEX_W-1:0]  last_index,
   output logic                          wr_en,
   output logic [stbl_pkg::ADDR_W-1:0]   rd_addr,
   input  stbl_pkg::entry_type           rd_data,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output stbl_pkg::result_type          rsp
);

   stbl_pkg::state_type              state_ff, state_in;
   logic [stbl_pkg::KEY_W-1:0]       key_ff, key_in;
   logic signed [stbl_pkg::BT_W-1:0] bottom_ff, bottom_in;
   logic signed [stbl_pkg::BT_W-1:0] top_ff, top_in;
   logic [stbl_pkg::ADDR_W-1:0]      mid_ff, mid_in;
   stbl_pkg::result_type             res_ff, res_in;
   stbl_pkg::result_type             rsp_ff, rsp_in;
   logic                             rsp_valid_ff, rsp_valid_in;
   stbl_pkg::probe_type              probe;
   stbl_pkg::result_type             res_now;
   logic                             out_free;

   stbl_probe u_probe (
      .key       (key_ff),
      .entry_key (rd_data.key),
      .bottom    (bottom_ff),
      .top       (top_ff),
      .mid       (mid_ff),
      .result    (probe)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= stbl_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff    <= key_in;
      bottom_ff <= bottom_in;
      top_ff    <= top_in;
      mid_ff    <= mid_in;
      res_ff    <= res_in;
      rsp_ff    <= rsp_in;
   end

   always_comb begin
      state_in     = state_ff;
      key_in       = key_ff;
      bottom_in    = bottom_ff;
      top_in       = top_ff;
      mid_in       = mid_ff;
      res_in       = res_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      req_ready    = 1'b0;
      wr_en        = 1'b0;
      rd_addr      = mid_ff;
      out_free     = !rsp_valid_ff || rsp_ready;

      res_now.found  = probe.hit;
      res_now.offset = probe.hit ? rd_data.offset : '0;
      res_now.length = probe.hit ? rd_data.length : '0;

      unique case (state_ff)
         stbl_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (req_op == stbl_pkg::OP_LOOKUP) begin
                  key_in    = req_key;
                  bottom_in = '0;
                  top_in    = $signed(stbl_pkg::BT_W'(last_index));
                  mid_in    = stbl_pkg::ADDR_W'(last_index >> 1);
                  rd_addr   = mid_in;
                  state_in  = stbl_pkg::ST_PROBE;
               end else begin
                  wr_en = 1'b1;
               end
            end
         end
         stbl_pkg::ST_PROBE: begin
            bottom_in = probe.bottom;
            top_in    = probe.top;
            mid_in    = probe.mid;
            rd_addr   = probe.mid;
            if (probe.done) begin
               res_in = res_now;
               if (out_free) begin
                  rsp_in       = res_now;
                  rsp_valid_in = 1'b1;
                  state_in     = stbl_pkg::ST_IDLE;
               end else begin
                  state_in = stbl_pkg::ST_HOLD;
               end
            end
         end
         stbl_pkg::ST_HOLD: begin
            if (out_free) begin
               rsp_in       = res_ff;
               rsp_valid_in = 1'b1;
               state_in     = stbl_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = stbl_pkg::ST_IDLE;
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

endmodule

// File: sv/sorted_table_binary_lookup_unit.sv
// Top level of the sorted table lookup unit: ports, range register, table memory.
// Depends on stbl_pkg, stbl_ram, stbl_seq and the defines header.
//
// A write item stores one table entry and gives no result. A
// lookup item binary-searches entries 0..last_index (keys sorted descending,
// compared as unsigned bit patterns) and gives one result. The search makes one
// probe per cycle, set by the registered read port of the table memory feeding
// the shared compare unit; the last probe's outcome goes to the output register.
// The input side is not ready while a lookup is in progress; a finished result
// may wait on the output while the next item is taken in.
`include "sorted_table_binary_lookup_unit_defines.svh"

module sorted_table_binary_lookup_unit (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [103:0] req_tdata,  // entry_index, search_key, entry_offset, entry_length
   input  logic         req_tuser,  // op
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [63:0]  rsp_tdata,  // msg_offset, msg_length
   output logic         rsp_tuser,  // found
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [7:0]   csr_data    // last_index
);

   logic [stbl_pkg::INDEX_W-1:0] last_index_ff;
   logic                         wr_en;
   logic [stbl_pkg::ADDR_W-1:0]  rd_addr;
   logic [stbl_pkg::ADDR_W-1:0]  wr_addr;
   stbl_pkg::entry_type          wr_entry;
   stbl_pkg::entry_type          rd_entry;
   stbl_pkg::result_type         rsp;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         last_index_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         last_index_ff <= csr_data;
      end
   end

   assign wr_addr         = stbl_pkg::ADDR_W'(req_tdata[7:0]);
   assign wr_entry.key    = req_tdata[39:8];
   assign wr_entry.offset = req_tdata[71:40];
   assign wr_entry.length = req_tdata[103:72];

   stbl_ram #(
      .DEPTH (stbl_pkg::TABLE_ENTRIES),
      .WIDTH (stbl_pkg::ENTRY_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_entry),
      .rd_addr (rd_addr),
      .rd_data (rd_entry)
   );

   stbl_seq u_seq (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_tvalid),
      .req_op     (req_tuser),
      .req_key    (req_tdata[39:8]),
      .req_ready  (req_tready),
      .last_index (last_index_ff),
      .wr_en      (wr_en),
      .rd_addr    (rd_addr),
      .rd_data    (rd_entry),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .rsp        (rsp)
   );

   assign rsp_tdata = {rsp.length, rsp.offset};
   assign rsp_tuser = rsp.found;

   `STBL_ASSERT_NOW(a_miss_zero, clock, reset, rsp_tvalid && !rsp_tuser, rsp_tdata == 64'd0, "miss with nonzero payload")
   `STBL_ASSERT_NEXT(a_write_silent, clock, reset, req_tvalid && req_tready && (req_tuser == stbl_pkg::OP_WRITE) && !rsp_tvalid, !rsp_tvalid, "write item produced a result")
   `STBL_ASSERT_NEXT(a_lookup_busy, clock, reset, req_tvalid && req_tready && (req_tuser == stbl_pkg::OP_LOOKUP), !req_tready, "intake open during lookup")

endmodule
